// ===== design/bbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the block buffer cache
// Codes for actions and result kinds, field widths and the queue entry type.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int GROUPS_DEF = 8;
  localparam int WAYS_DEF   = 4;
  localparam int DEV_W      = 16;
  localparam int BLK_W      = 32;
  localparam int SLOT_W     = 5;
  localparam int REF_W      = 8;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_DIRTY   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_SYNC    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_HIT      = 3'd0,
    K_MISS     = 3'd1,
    K_NOBUF    = 3'd2,
    K_DIRTY    = 3'd3,
    K_RELEASED = 3'd4,
    K_RELERR   = 3'd5,
    K_SYNCWB   = 3'd6,
    K_SYNCDONE = 3'd7
  } kind_t;

  typedef struct packed {
    action_t           action;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic              want_data;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/bbc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_in_if / bbc_out_if: valid-ready channels of the buffer cache
// Input beats carry requests, output beats carry results.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [bbc_pkg::DEV_W-1:0] device;
  logic [bbc_pkg::BLK_W-1:0] block_number;
  logic                      want_data;
  logic [bbc_pkg::SLOT_W-1:0] slot;
  modport source (output valid, action, device, block_number, want_data, slot,
                  input ready);
  modport sink (input valid, action, device, block_number, want_data, slot,
                output ready);
endinterface

interface bbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [bbc_pkg::SLOT_W-1:0] slot_out;
  logic                       fetch_request;
  logic                       writeback_request;
  logic [bbc_pkg::DEV_W-1:0]  writeback_device;
  logic [bbc_pkg::BLK_W-1:0]  writeback_block;
  logic                       last;
  modport source (output valid, kind, slot_out, fetch_request, writeback_request,
                  writeback_device, writeback_block, last, input ready);
  modport sink (input valid, kind, slot_out, fetch_request, writeback_request,
                writeback_device, writeback_block, last, output ready);
endinterface
`default_nettype wire

// ===== design/bbc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_front: request intake and command queue
// Take input beats into a small FIFO that decouples intake from execution.
// ----------------------------------------------------------------------------
module bbc_front (
  input  wire logic  clk,
  input  wire logic  rst,
  bbc_in_if.sink     req,
  output bbc_pkg::cmd_t cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_take
);
  localparam int DEPTH = 2;

  bbc_pkg::cmd_t q [DEPTH];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;

  assign req.ready = (cnt != 2'(DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{action: bbc_pkg::action_t'(req.action), device: req.device,
                 block_number: req.block_number, want_data: req.want_data,
                 slot: req.slot};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (cmd_take) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(cmd_take);
    end
  end
endmodule
`default_nettype wire

// ===== design/bbc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_back: tag controller execution engine
// Run one command at a time against the slot state and emit result beats.
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int GROUPS = bbc_pkg::GROUPS_DEF,
  parameter int WAYS   = bbc_pkg::WAYS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  bbc_pkg::cmd_t cmd,
  input  wire logic     cmd_valid,
  output logic          cmd_take,
  bbc_out_if.source     rsp
);
  localparam int NS  = GROUPS * WAYS;
  localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int SCW = $clog2(NS + 1);
  localparam int RW  = bbc_pkg::REF_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EXEC = 5'b00100,
    S_SYNC = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  // tag memory, one entry per slot
  logic [bbc_pkg::DEV_W-1:0] tdev [NS];
  logic [bbc_pkg::BLK_W-1:0] tblk [NS];
  logic [NS-1:0] occ, dval, dirty;
  logic [RW-1:0] refc [NS];
  logic [WW-1:0] rank [NS];

  bbc_pkg::cmd_t c;
  logic [GW-1:0] grp;
  logic [WAYS-1:0] hitv;
  logic [SCW-1:0] sidx;
  logic            last_sync;

  // output register
  logic                        o_valid;
  bbc_pkg::kind_t              o_kind;
  logic [bbc_pkg::SLOT_W-1:0]  o_slot;
  logic                        o_fetch, o_wb, o_last;
  logic [bbc_pkg::DEV_W-1:0]   o_dev;
  logic [bbc_pkg::BLK_W-1:0]   o_blk;

  assign rsp.valid = o_valid;
  assign rsp.kind = o_kind;
  assign rsp.slot_out = o_slot;
  assign rsp.fetch_request = o_fetch;
  assign rsp.writeback_request = o_wb;
  assign rsp.writeback_device = o_dev;
  assign rsp.writeback_block = o_blk;
  assign rsp.last = o_last;

  logic out_free;
  assign out_free = !o_valid || rsp.ready;
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  function automatic logic [SW-1:0] sl(input logic [GW-1:0] g, input int w);
    return SW'(int'(g) * WAYS + w);
  endfunction

  // victim and hit search over the group ways
  logic          vfound, hfound;
  logic [WW-1:0] vway, hway;
  always_comb begin
    vfound = 1'b0;
    vway = '0;
    hfound = 1'b0;
    hway = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (refc[sl(grp, w)] == '0 &&
          (!vfound || rank[sl(grp, w)] < rank[sl(grp, 32'(vway))])) begin
        vfound = 1'b1;
        vway = WW'(w);
      end
      if (hitv[w] && !hfound) begin
        hfound = 1'b1;
        hway = WW'(w);
      end
    end
  end

  logic [SW-1:0] vs, hs, cs, ss;
  logic          cs_ok;
  assign vs = sl(grp, 32'(vway));
  assign hs = sl(grp, 32'(hway));
  assign cs_ok = (32'(c.slot) < NS);
  assign cs = SW'(c.slot);
  assign ss = SW'(sidx);
  assign last_sync = (sidx == SCW'(NS - 1));

  // miss that evicts a valid dirty block carries a writeback
  logic is_miss, miss_wb, post;
  assign is_miss = (c.action == bbc_pkg::ACT_ACQUIRE) && !hfound && vfound;
  assign miss_wb = is_miss && dval[vs] && dirty[vs];
  // a beat is loaded into the output register this cycle
  assign post = out_free && ((state == S_EXEC) || (state == S_OUT) ||
                             ((state == S_SYNC) && dval[ss] && dirty[ss]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      o_valid <= 1'b0;
      occ <= '0;
      dval <= '0;
      dirty <= '0;
      for (int i = 0; i < NS; i++) begin
        refc[i] <= '0;
        rank[i] <= WW'(i % WAYS);
      end
    end else begin
      if (post) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c <= cmd;
            grp <= GW'(cmd.block_number % GROUPS);
            sidx <= '0;
            state <= (cmd.action == bbc_pkg::ACT_SYNC) ? S_SYNC :
                     (cmd.action == bbc_pkg::ACT_ACQUIRE) ? S_LOOK : S_EXEC;
          end
        end
        S_LOOK: begin
          for (int w = 0; w < WAYS; w++)
            hitv[w] <= occ[sl(grp, w)] && tdev[sl(grp, w)] == c.device &&
                       tblk[sl(grp, w)] == c.block_number;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            o_last <= 1'b1;
            o_fetch <= is_miss && c.want_data;
            o_wb <= miss_wb;
            o_dev <= miss_wb ? tdev[vs] : '0;
            o_blk <= miss_wb ? tblk[vs] : '0;
            state <= S_IDLE;
            unique case (c.action)
              bbc_pkg::ACT_ACQUIRE: begin
                if (hfound) begin
                  o_kind <= bbc_pkg::K_HIT;
                  o_slot <= bbc_pkg::SLOT_W'(hs);
                  if (refc[hs] != bbc_pkg::REF_MAX) refc[hs] <= refc[hs] + RW'(1);
                  dval[hs] <= 1'b1;
                end else if (!vfound) begin
                  o_kind <= bbc_pkg::K_NOBUF;
                  o_slot <= '0;
                end else begin
                  o_kind <= bbc_pkg::K_MISS;
                  o_slot <= bbc_pkg::SLOT_W'(vs);
                  tdev[vs] <= c.device;
                  tblk[vs] <= c.block_number;
                  occ[vs] <= 1'b1;
                  dval[vs] <= 1'b1;
                  dirty[vs] <= 1'b0;
                  refc[vs] <= RW'(1);
                end
              end
              bbc_pkg::ACT_DIRTY: begin
                o_kind <= bbc_pkg::K_DIRTY;
                o_slot <= c.slot;
                if (cs_ok) dirty[cs] <= 1'b1;
              end
              bbc_pkg::ACT_RELEASE: begin
                o_slot <= c.slot;
                if (!cs_ok || refc[cs] == '0) begin
                  o_kind <= bbc_pkg::K_RELERR;
                end else begin
                  o_kind <= bbc_pkg::K_RELEASED;
                  refc[cs] <= refc[cs] - RW'(1);
                  if (refc[cs] == RW'(1)) begin
                    // move to most-recent end, close the gap
                    for (int w = 0; w < WAYS; w++)
                      if (rank[sl(GW'(cs / WAYS), w)] > rank[cs])
                        rank[sl(GW'(cs / WAYS), w)] <=
                          rank[sl(GW'(cs / WAYS), w)] - WW'(1);
                    rank[cs] <= WW'(WAYS - 1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SYNC: begin
          // one slot per cycle; stall when a writeback beat cannot be posted
          if (dval[ss] && dirty[ss]) begin
            if (out_free) begin
              o_kind <= bbc_pkg::K_SYNCWB;
              o_slot <= bbc_pkg::SLOT_W'(ss);
              o_fetch <= 1'b0;
              o_wb <= 1'b1;
              o_dev <= tdev[ss];
              o_blk <= tblk[ss];
              o_last <= 1'b0;
              dirty[ss] <= 1'b0;
              sidx <= sidx + SCW'(1);
              if (last_sync) state <= S_OUT;
            end
          end else begin
            sidx <= sidx + SCW'(1);
            if (last_sync) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            o_kind <= bbc_pkg::K_SYNCDONE;
            o_slot <= '0;
            o_fetch <= 1'b0;
            o_wb <= 1'b0;
            o_dev <= '0;
            o_blk <= '0;
            o_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/block_buffer_cache_lru_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top: set-associative disk buffer cache tag controller
// Tracks tags, reference counts, dirty state and LRU order of cache slots.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat (acquire, mark dirty, release, sync).
//   rsp carries result beats; last marks the final beat of a request.
//   A two-entry command queue in the front accepts beats while the back
//   works, so intake and execution stall independently.
// Steps:
//   Acquire runs capture, tag compare and update in the back; mark dirty
//   and release run capture and update. Sync captures, walks every slot
//   in turn and then posts the done beat, taking longer when rsp stalls.
// Reset:
//   rst (synchronous) clears occupancy, dirty, data-valid and reference
//   counts, sets each slot's rank to its way index and empties the queue.
//   Tag storage is not cleared; it is read only for occupied slots.
// Stall:
//   When rsp.ready is low the result register holds its beat and the back
//   waits; the front keeps filling its queue until it is full.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
  parameter int GROUPS = bbc_pkg::GROUPS_DEF,
  parameter int WAYS   = bbc_pkg::WAYS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bbc_in_if.sink   req,
  bbc_out_if.source rsp
);
  bbc_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  // front: accept and queue beats
  bbc_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  // back: execute against slot state
  bbc_back #(.GROUPS(GROUPS), .WAYS(WAYS)) u_back (
    .clk(clk), .rst(rst),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .rsp(rsp)
  );
endmodule
`default_nettype wire
